>>> rtl/eab_pkg.sv
`default_nettype none
package eab_pkg;

  // Number formats
  localparam int ANGLE_FRAC_BITS = 28;
  localparam int CORDIC_STEPS    = 30;
  localparam int ANGLE_W         = ANGLE_FRAC_BITS + 4;
  localparam int SIN_W           = ANGLE_FRAC_BITS + 6;
  localparam int ECC_W           = 16;
  localparam int PROD_W          = SIN_W + ECC_W + 1;
  localparam int TOL_W           = 29;
  localparam int CNT_W           = 6;
  localparam int STEP_W          = $clog2(CORDIC_STEPS);
  localparam int CFG_IDX_W       = 8;
  localparam int CFG_DATA_W      = 32;
  localparam int MAX_HALVINGS    = ANGLE_FRAC_BITS + 4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ECCENTRICITY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE    = CFG_IDX_W'(1);

  localparam logic [ECC_W-1:0] ECC_RESET = '0;
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(268);

  // Angle constants
  localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
  localparam logic [63:0] TWO_PI_Q58  = PI_Q60 >> 1;
  localparam logic [63:0] PI_Q58      = PI_Q60 >> 2;
  localparam logic [63:0] HALF_PI_Q58 = PI_Q60 >> 3;
  localparam logic [63:0] GAIN_Q60    = 64'h9B74EDA8 << 28;
  localparam logic [63:0] HI_INIT_64  =
    (PI_Q60 + (64'd1 << (57 - ANGLE_FRAC_BITS))) >> (58 - ANGLE_FRAC_BITS);
  localparam logic [ANGLE_W-1:0] HI_INIT = HI_INIT_64[ANGLE_W-1:0];
  localparam int          SIN_SHIFT = 60 - ANGLE_FRAC_BITS;
  localparam logic [63:0] SIN_RND   = 64'd1 << (59 - ANGLE_FRAC_BITS);

  typedef logic [63:0] atan_tab_t [CORDIC_STEPS];

  // Restoring long division, shift and subtract one quotient bit at a time
  function automatic logic [63:0] long_div(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    int          b;
    quo = '0;
    rem = '0;
    for (b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(2^-i) in Q60 from the alternating series, worked out at elaboration
  function automatic atan_tab_t build_atan_tab();
    atan_tab_t       tab;
    logic [63:0]     sum;
    logic [63:0]     term;
    logic [63:0]     divisor;
    int              i;
    int              k;
    tab[0] = PI_Q60 >> 2;
    for (i = 1; i < CORDIC_STEPS; i++) begin
      sum = '0;
      for (k = 0; i * (2 * k + 1) <= 60; k++) begin
        divisor = 64'(2 * k + 1);
        term = long_div(64'd1 << (60 - i * (2 * k + 1)), divisor);
        if ((k % 2) == 1) sum = sum - term;
        else sum = sum + term;
      end
      tab[i] = sum;
    end
    return tab;
  endfunction

  localparam atan_tab_t ATAN_TAB = build_atan_tab();

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TEST,
    ST_REDUCE,
    ST_FOLD,
    ST_MIRROR,
    ST_ROTATE,
    ST_SINE,
    ST_SCALE,
    ST_EVAL,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

>>> rtl/eab_in_if.sv
`default_nettype none
interface eab_in_if;
  import eab_pkg::*;
  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] mean_anomaly;
  modport source (output valid, output mean_anomaly, input ready);
  modport sink (input valid, input mean_anomaly, output ready);
endinterface
`default_nettype wire

>>> rtl/eab_out_if.sv
`default_nettype none
interface eab_out_if;
  import eab_pkg::*;
  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] eccentric_anomaly;
  logic [CNT_W-1:0]   iteration_count;
  modport source (output valid, output eccentric_anomaly, output iteration_count,
                  input ready);
  modport sink (input valid, input eccentric_anomaly, input iteration_count,
                output ready);
endinterface
`default_nettype wire

>>> rtl/eab_cfg_if.sv
`default_nettype none
interface eab_cfg_if;
  import eab_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/eccentric_anomaly_bisection.sv
// Channel   Direction  Payload
// in_ch     sink       mean_anomaly (Q4.28 rad)
// out_ch    source     eccentric_anomaly (Q4.28 rad), iteration_count
// cfg_ch    sink       index, data (0: eccentricity, 1: tolerance)
//
// One evaluation of f runs range reduction, folding, mirroring, the CORDIC rotation,
// sine extraction, scaling and the sign test, and a request needs up to 33 of them
// (f at zero, then one per halving), all through the shared CORDIC stage.
// Reset (rst_n low, synchronous) returns to idle and restores the registers.
// in_ch is not ready while a request is in work; the result holds on out_ch
// until taken. cfg_ch is always ready.
`default_nettype none
module eccentric_anomaly_bisection
  import eab_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  eab_in_if.sink     in_ch,
  eab_out_if.source  out_ch,
  eab_cfg_if.sink    cfg_ch
);

  state_t state_r, state_nxt;

  logic [ECC_W-1:0]   ecc_r;
  logic [TOL_W-1:0]   tol_r;
  logic [ANGLE_W-1:0] m_r, lo_r, hi_r, arg_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               first_r;
  logic               sa_neg_r, sa_pos_r;
  logic [63:0]        r_r, x_r, y_r, z_r;
  logic               neg_r;
  logic [STEP_W-1:0]  step_r;
  logic signed [SIN_W-1:0]  sin_r;
  logic signed [PROD_W-1:0] p_r;

  logic [ANGLE_W:0]   sum_w;
  logic [ANGLE_W-1:0] mid_w;
  logic [ANGLE_W-1:0] width_w;
  logic               go_on_w;
  logic [63:0]        mirror_w;
  logic [63:0]        x_sh_w, y_sh_w;
  logic [63:0]        y_neg_w, sin_full_w;
  logic [PROD_W-1:0]  es_w;
  logic [63:0]        f_w;
  logic               sc_neg_w, sc_pos_w, split_w;

  // Bracket midpoint and loop test
  assign sum_w   = {1'b0, hi_r} + {1'b0, lo_r};
  assign mid_w   = sum_w[ANGLE_W:1];
  assign width_w = hi_r - lo_r;
  assign go_on_w = ({1'b0, width_w} > (ANGLE_W + 1)'({tol_r, 1'b0}))
                   && (cnt_r < CNT_W'(MAX_HALVINGS));

  // Fold above pi/2 onto the first quadrant
  assign mirror_w = (r_r > HALF_PI_Q58) ? (PI_Q58 - r_r) : r_r;

  // CORDIC shifts
  assign x_sh_w = 64'($signed(x_r) >>> step_r);
  assign y_sh_w = 64'($signed(y_r) >>> step_r);

  // Sine in Q.F with rounding
  assign y_neg_w    = neg_r ? (64'd0 - y_r) : y_r;
  assign sin_full_w = 64'($signed(y_neg_w + SIN_RND) >>> SIN_SHIFT);

  // f = E - e*sin(E) - M
  assign es_w = PROD_W'($signed(p_r + PROD_W'(32'h8000)) >>> 16);
  assign f_w  = 64'(arg_r) - {{(64 - PROD_W){es_w[PROD_W-1]}}, es_w} - 64'(m_r);
  assign sc_neg_w = f_w[63];
  assign sc_pos_w = !f_w[63] && (f_w != '0);
  assign split_w  = (sa_neg_r && sc_pos_w) || (sa_pos_r && sc_neg_w);

  // Hold the state
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // Sequence one request
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_ch.valid) state_nxt = ST_TEST;
      ST_TEST:   state_nxt = go_on_w ? ST_REDUCE : ST_DONE;
      ST_REDUCE: if (r_r < TWO_PI_Q58) state_nxt = ST_FOLD;
      ST_FOLD:   state_nxt = ST_MIRROR;
      ST_MIRROR: state_nxt = ST_ROTATE;
      ST_ROTATE: if (step_r == STEP_W'(CORDIC_STEPS - 1)) state_nxt = ST_SINE;
      ST_SINE:   state_nxt = ST_SCALE;
      ST_SCALE:  state_nxt = ST_EVAL;
      ST_EVAL:   state_nxt = ST_TEST;
      ST_DONE:   if (out_ch.ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ecc_r <= ECC_RESET;
      tol_r <= TOL_RESET;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == REG_ECCENTRICITY) ecc_r <= cfg_ch.data[ECC_W-1:0];
      else if (cfg_ch.index == REG_TOLERANCE) tol_r <= cfg_ch.data[TOL_W-1:0];
    end
  end

  // Bisection datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        m_r     <= in_ch.mean_anomaly;
        lo_r    <= '0;
        hi_r    <= HI_INIT;
        cnt_r   <= '0;
        first_r <= 1'b1;
      end
      ST_TEST: begin
        arg_r <= first_r ? lo_r : mid_w;
        r_r   <= 64'(first_r ? lo_r : mid_w) << (58 - ANGLE_FRAC_BITS);
        neg_r <= 1'b0;
      end
      ST_REDUCE: if (r_r >= TWO_PI_Q58) r_r <= r_r - TWO_PI_Q58;
      ST_FOLD: if (r_r >= PI_Q58) begin
        r_r   <= r_r - PI_Q58;
        neg_r <= 1'b1;
      end
      ST_MIRROR: begin
        z_r    <= mirror_w << 2;
        x_r    <= GAIN_Q60;
        y_r    <= '0;
        step_r <= '0;
      end
      ST_ROTATE: begin
        if (z_r[63]) begin
          x_r <= x_r + y_sh_w;
          y_r <= y_r - x_sh_w;
          z_r <= z_r + ATAN_TAB[step_r];
        end else begin
          x_r <= x_r - y_sh_w;
          y_r <= y_r + x_sh_w;
          z_r <= z_r - ATAN_TAB[step_r];
        end
        step_r <= step_r + STEP_W'(1);
      end
      ST_SINE:  sin_r <= $signed(sin_full_w[SIN_W-1:0]);
      ST_SCALE: p_r <= $signed({1'b0, ecc_r}) * sin_r;
      ST_EVAL: begin
        if (first_r) begin
          first_r  <= 1'b0;
          sa_neg_r <= sc_neg_w;
          sa_pos_r <= sc_pos_w;
        end else begin
          // Advance the bracket; f(lo) follows lo
          if (split_w) hi_r <= arg_r;
          else begin
            lo_r     <= arg_r;
            sa_neg_r <= sc_neg_w;
            sa_pos_r <= sc_pos_w;
          end
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  assign in_ch.ready              = (state_r == ST_IDLE);
  assign cfg_ch.ready             = 1'b1;
  assign out_ch.valid             = (state_r == ST_DONE);
  assign out_ch.eccentric_anomaly = mid_w;
  assign out_ch.iteration_count   = cnt_r;

`ifndef SYNTHESIS
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (cnt_r <= CNT_W'(MAX_HALVINGS)))
    else $error("halving count beyond cap");
  a_bracket: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (lo_r <= hi_r))
    else $error("bracket inverted");
  a_rot_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROTATE && step_r == STEP_W'(CORDIC_STEPS - 1)) |=> (state_r == ST_SINE))
    else $error("rotation length wrong");
  a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> ($past(state_r) == ST_TEST))
    else $error("result without loop exit");
`endif

endmodule
`default_nettype wire

>>> bench/eab_tb_if.sv
`timescale 1ns / 1ps
// Types shared by the bench
package eab_tb_pkg;
  import eab_pkg::*;

  // One row of directed stimulus
  typedef struct {
    logic [ANGLE_W-1:0] anomaly;
    bit                 known;
    logic [ANGLE_W-1:0] want_angle;
    logic [CNT_W-1:0]   want_count;
  } anomaly_row_t;
endpackage

>>> bench/eccentric_anomaly_bisection_tb.sv
`timescale 1ns / 1ps
module eccentric_anomaly_bisection_tb;
  import eab_pkg::*;
  import eab_tb_pkg::*;

  typedef struct {
    logic [ANGLE_W-1:0] angle;
    logic [CNT_W-1:0]   count;
  } solution_t;

  logic clk;
  logic rst_n;

  eab_in_if  in_ch ();
  eab_out_if out_ch ();
  eab_cfg_if cfg_ch ();

  eccentric_anomaly_bisection dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  // Model copies of the registers
  logic [ECC_W-1:0] ecc_now;
  logic [TOL_W-1:0] tol_now;

  solution_t pending_solutions[$];
  int        errors;
  int        solved;
  bit        hold_off;
  bit        calm;

  function automatic logic [63:0] shr_arith(logic [63:0] v, int s);
    return $signed(v) >>> s;
  endfunction

  // Arctangent of 2^-i in Q60 from its alternating series
  function automatic logic [63:0] arctan_q60(int i);
    logic [63:0] acc;
    logic [63:0] term;
    int          k;
    acc = '0;
    if (i == 0) return PI_Q60 >> 2;
    for (k = 0; i * (2 * k + 1) <= 60; k++) begin
      term = (64'd1 << (60 - i * (2 * k + 1))) / 64'(2 * k + 1);
      if (k % 2 == 1) acc = acc - term;
      else acc = acc + term;
    end
    return acc;
  endfunction

  // Sine of a Q4.28 angle, returned in two's complement Q.28
  function automatic logic [63:0] sine_q28(logic [63:0] a);
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] z;
    logic [63:0] nx;
    bit          flip;
    int          i;
    r = a << (58 - ANGLE_FRAC_BITS);
    flip = 0;
    while (r >= (PI_Q60 >> 1)) r = r - (PI_Q60 >> 1);
    if (r >= (PI_Q60 >> 2)) begin
      r = r - (PI_Q60 >> 2);
      flip = 1;
    end
    if (r > (PI_Q60 >> 3)) r = (PI_Q60 >> 2) - r;
    z = r << 2;
    x = 64'h9B74EDA8 << 28;
    y = '0;
    for (i = 0; i < CORDIC_STEPS; i++) begin
      if (z[63]) begin
        nx = x + shr_arith(y, i);
        y  = y - shr_arith(x, i);
        z  = z + arctan_q60(i);
      end else begin
        nx = x - shr_arith(y, i);
        y  = y + shr_arith(x, i);
        z  = z - arctan_q60(i);
      end
      x = nx;
    end
    if (flip) y = 64'd0 - y;
    return shr_arith(y + (64'd1 << (59 - ANGLE_FRAC_BITS)), 60 - ANGLE_FRAC_BITS);
  endfunction

  function automatic int kepler_sign(logic [63:0] ang, logic [63:0] m);
    logic [63:0] prod;
    logic [63:0] f;
    prod = {48'd0, ecc_now} * sine_q28(ang);
    f = ang - shr_arith(prod + 64'h8000, 16) - m;
    if (f[63]) return -1;
    return (f != 0) ? 1 : 0;
  endfunction

  // Bisect Kepler's equation over [0, 4*pi]
  function automatic solution_t solve_kepler(logic [ANGLE_W-1:0] m);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    int          n;
    solution_t   s;
    lo = '0;
    hi = (PI_Q60 + (64'd1 << (57 - ANGLE_FRAC_BITS))) >> (58 - ANGLE_FRAC_BITS);
    n = 0;
    while (hi - lo > 2 * {35'd0, tol_now} && n < MAX_HALVINGS) begin
      mid = (hi + lo) >> 1;
      if (kepler_sign(lo, {32'd0, m}) * kepler_sign(mid, {32'd0, m}) < 0) hi = mid;
      else lo = mid;
      n++;
    end
    s.angle = ANGLE_W'((hi + lo) >> 1);
    s.count = CNT_W'(n);
    return s;
  endfunction

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("eccentric_anomaly_bisection_tb failed");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    int n;
    out_ch.ready <= 0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off) begin
        out_ch.ready <= 0;
        repeat (4000) @(posedge clk);
        hold_off = 0;
      end
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 0;
        n = $urandom_range(1, 15);
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1;
      @(posedge clk);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    solution_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_solutions.size() == 0) begin
        $display("%0t: unexpected result angle %h count %0d", $time,
                 out_ch.eccentric_anomaly, out_ch.iteration_count);
        errors++;
      end else begin
        w = pending_solutions.pop_front();
        if (out_ch.eccentric_anomaly !== w.angle) begin
          $display("%0t: angle expected %h actual %h", $time, w.angle,
                   out_ch.eccentric_anomaly);
          errors++;
        end
        if (out_ch.iteration_count !== w.count) begin
          $display("%0t: count expected %0d actual %0d", $time, w.count,
                   out_ch.iteration_count);
          errors++;
        end
        solved++;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk iff cfg_ch.ready);
    cfg_ch.valid <= 0;
    if (idx == REG_ECCENTRICITY) ecc_now = val[ECC_W-1:0];
    else if (idx == REG_TOLERANCE) tol_now = val[TOL_W-1:0];
  endtask

  // Offer one request; gaps come before it at random
  task automatic send_anomaly(logic [ANGLE_W-1:0] m, bit gaps);
    int n;
    if (gaps && !calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 0;
      n = $urandom_range(1, 15);
      repeat (n) @(posedge clk);
    end
    in_ch.valid        <= 1;
    in_ch.mean_anomaly <= m;
    @(posedge clk iff in_ch.ready);
    pending_solutions.push_back(solve_kepler(m));
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (pending_solutions.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic logic [ANGLE_W-1:0] pick_anomaly();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return $urandom_range(0, 4096);
      default: return $urandom_range(0, 32'd3373259426);
    endcase
  endfunction

  initial begin
    anomaly_row_t rows[$];
    solution_t    w;
    int           p;
    int           i;
    errors = 0;
    solved = 0;
    hold_off = 0;
    calm = 0;
    ecc_now = ECC_RESET;
    tol_now = TOL_RESET;
    rst_n <= 0;
    in_ch.valid <= 0;
    in_ch.mean_anomaly <= '0;
    cfg_ch.valid <= 0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed rows with reset registers, all checked against the predictor
    rows.push_back('{32'd0, 0, '0, '0});
    rows.push_back('{32'd3373259426, 0, '0, '0});
    rows.push_back('{32'hFFFFFFFF, 0, '0, '0});
    rows.push_back('{32'h80000000, 0, '0, '0});
    rows.push_back('{32'h00000001, 0, '0, '0});
    rows.push_back('{32'h3243F6A8, 0, '0, '0});
    rows.push_back('{32'h7FFFFFFF, 0, '0, '0});
    foreach (rows[j]) begin
      if (rows[j].known) begin
        w = solve_kepler(rows[j].anomaly);
        if (w.angle !== rows[j].want_angle || w.count !== rows[j].want_count) begin
          $display("%0t: row expected %h/%0d actual %h/%0d", $time,
                   rows[j].want_angle, rows[j].want_count, w.angle, w.count);
          errors++;
        end
      end
      send_anomaly(rows[j].anomaly, 0);
    end
    drain();

    // Extremes of both registers, including zero tolerance and its halving cap
    write_reg(REG_ECCENTRICITY, 32'hFFFF);
    write_reg(REG_TOLERANCE, 32'd0);
    write_reg(8'd7, 32'h12345678);
    send_anomaly(32'd0, 0);
    send_anomaly(32'd3373259426, 0);
    send_anomaly(32'hFFFFFFFF, 0);
    send_anomaly(32'h55555555, 0);
    drain();
    write_reg(REG_TOLERANCE, 32'h10000000);
    write_reg(REG_ECCENTRICITY, 32'd0);
    send_anomaly(32'h12345678, 0);
    send_anomaly(32'hAAAAAAAA, 0);
    drain();
    write_reg(REG_TOLERANCE, 32'h1FFFFFFF);
    send_anomaly(32'h22222222, 0);
    drain();
    write_reg(REG_TOLERANCE, 32'hFFFFFFFF);
    send_anomaly(32'h40000000, 0);
    drain();

    // Random phases under several settings
    for (p = 0; p < 6; p++) begin
      write_reg(REG_ECCENTRICITY, (p == 0) ? 32'hFFFF : $urandom);
      write_reg(REG_TOLERANCE, (p == 1) ? 32'd1 : $urandom_range(1, 4096));
      if (p == 5) calm = 1;
      for (i = 0; i < 80; i++) begin
        if (p == 2 && i == 10) hold_off = 1;
        send_anomaly(pick_anomaly(), 1);
      end
      drain();
    end

    $display("covered %0d solutions over many register settings, with stalls,", solved);
    $display("a long receiver hold-off, zero tolerance and out-of-range anomalies");
    if (errors == 0) $display("eccentric_anomaly_bisection_tb passed");
    else $display("eccentric_anomaly_bisection_tb failed");
    $finish;
  end
endmodule

>>> filelist.f
rtl/eab_pkg.sv
rtl/eab_in_if.sv
rtl/eab_out_if.sv
rtl/eab_cfg_if.sv
rtl/eccentric_anomaly_bisection.sv
bench/eab_tb_if.sv
bench/eccentric_anomaly_bisection_tb.sv
